// ===== hdl/mmq_pkg.sv =====
`default_nettype none

package mmq_pkg;

  localparam int unsigned DEPTH       = 64;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned COUNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned ERR_W       = 2;

  localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  localparam logic [ERR_W-1:0] ERR_OK         = 2'd0;
  localparam logic [ERR_W-1:0] ERR_PUSH_FULL  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_POP_EMPTY  = 2'd2;

  // One stack entry: the value and the running min/max from the bottom up to it.
  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] val;
    logic signed [VALUE_WIDTH-1:0] mn;
    logic signed [VALUE_WIDTH-1:0] mx;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/mmq_cell.sv =====
`default_nettype none

module mmq_cell (
  input  wire                logic      clk_i,
  input  wire mmq_pkg::stk_ctrl_t       ctrl_i,
  input  wire mmq_pkg::entry_t          above_i,
  input  wire mmq_pkg::entry_t          below_i,
  output mmq_pkg::entry_t               entry_o
);

  mmq_pkg::entry_t entry_q;
  mmq_pkg::entry_t entry_d;

  // Push moves entries one cell deeper, pop moves them one cell toward the top.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.push) begin
      entry_d = above_i;
    end else if (ctrl_i.pop) begin
      entry_d = below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// ===== hdl/mmq_stack.sv =====
`default_nettype none

module mmq_stack (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire mmq_pkg::stk_ctrl_t                ctrl_i,
  input  wire logic signed [mmq_pkg::VALUE_WIDTH-1:0] push_val_i,
  output mmq_pkg::entry_t                        top_o,
  output logic [mmq_pkg::COUNT_W-1:0]            depth_o
);

  mmq_pkg::entry_t                 cell_out [mmq_pkg::DEPTH];
  mmq_pkg::entry_t                 new_entry;
  logic [mmq_pkg::COUNT_W-1:0]     depth_q;
  logic [mmq_pkg::COUNT_W-1:0]     depth_d;

  // Fold the pushed value into the running min/max of the current top.
  always_comb begin
    new_entry.val = push_val_i;
    new_entry.mn  = push_val_i;
    new_entry.mx  = push_val_i;
    if (depth_q != '0) begin
      if ($signed(cell_out[0].mn) < $signed(push_val_i)) begin
        new_entry.mn = cell_out[0].mn;
      end
      if ($signed(cell_out[0].mx) > $signed(push_val_i)) begin
        new_entry.mx = cell_out[0].mx;
      end
    end
  end

  for (genvar i = 0; i < mmq_pkg::DEPTH; i++) begin : g_cell
    mmq_pkg::entry_t above;
    mmq_pkg::entry_t below;

    if (i == 0) begin : g_first
      assign above = new_entry;
    end else begin : g_mid_a
      assign above = cell_out[i-1];
    end

    if (i == mmq_pkg::DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_mid_b
      assign below = cell_out[i+1];
    end

    mmq_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .above_i (above),
      .below_i (below),
      .entry_o (cell_out[i])
    );
  end

  always_comb begin
    depth_d = depth_q;
    if (ctrl_i.push) begin
      depth_d = depth_q + mmq_pkg::COUNT_W'(1);
    end else if (ctrl_i.pop) begin
      depth_d = depth_q - mmq_pkg::COUNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else begin
      depth_q <= depth_d;
    end
  end

  assign top_o   = cell_out[0];
  assign depth_o = depth_q;

endmodule

`default_nettype wire

// ===== hdl/min_max_fifo_queue_top.sv =====
// Channel   Handshake                 Payload
// in        in_valid_i / in_ready_o   action_i, value_i
// out       out_valid_o / out_ready_i popped_value_o, oldest_value_o, window_min_o,
//                                     window_max_o, held_count_o, error_code_o
//
// A push passes through accept, execute and report; the result is registered in the
// report state and the next transaction is taken once the block is back in idle.
// A pop with a non-empty front stack does the same; one that finds it empty and the
// back stack not empty moves it over first, one entry per cycle, and executes again.
// Reset clears both stack depths and the control state; no clearing pass is needed.
// A result waiting in the output register stalls the report state and the input.
`default_nettype none

module min_max_fifo_queue_top (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      in_valid_i,
  output logic                                           in_ready_o,
  input  wire logic                                      action_i,
  input  wire logic signed [mmq_pkg::VALUE_WIDTH-1:0]    value_i,
  output logic                                           out_valid_o,
  input  wire logic                                      out_ready_i,
  output logic signed [mmq_pkg::VALUE_WIDTH-1:0]         popped_value_o,
  output logic signed [mmq_pkg::VALUE_WIDTH-1:0]         oldest_value_o,
  output logic signed [mmq_pkg::VALUE_WIDTH-1:0]         window_min_o,
  output logic signed [mmq_pkg::VALUE_WIDTH-1:0]         window_max_o,
  output logic [mmq_pkg::COUNT_W-1:0]                    held_count_o,
  output logic [mmq_pkg::ERR_W-1:0]                      error_code_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_MOVE   = 2'd2;
  localparam logic [1:0] ST_REPORT = 2'd3;

  logic [1:0] state_q, state_d;

  logic                                   act_q;
  logic signed [mmq_pkg::VALUE_WIDTH-1:0] value_q;
  logic signed [mmq_pkg::VALUE_WIDTH-1:0] popped_q, popped_d;
  logic [mmq_pkg::ERR_W-1:0]              err_q, err_d;
  logic signed [mmq_pkg::VALUE_WIDTH-1:0] bottom_q;

  logic                                   out_valid_q;
  logic signed [mmq_pkg::VALUE_WIDTH-1:0] res_popped_q, res_oldest_q, res_min_q, res_max_q;
  logic [mmq_pkg::COUNT_W-1:0]            res_count_q;
  logic [mmq_pkg::ERR_W-1:0]              res_err_q;

  mmq_pkg::stk_ctrl_t                     front_ctrl, back_ctrl;
  logic signed [mmq_pkg::VALUE_WIDTH-1:0] front_push_val;
  mmq_pkg::entry_t                        front_top, back_top;
  logic [mmq_pkg::COUNT_W-1:0]            front_depth, back_depth, held;

  logic                                   in_fire, load_out;
  logic signed [mmq_pkg::VALUE_WIDTH-1:0] rep_oldest, rep_min, rep_max;

  mmq_stack u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (front_ctrl),
    .push_val_i (front_push_val),
    .top_o      (front_top),
    .depth_o    (front_depth)
  );

  mmq_stack u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (back_ctrl),
    .push_val_i (value_q),
    .top_o      (back_top),
    .depth_o    (back_depth)
  );

  assign held       = front_depth + back_depth;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign load_out   = (state_q == ST_REPORT) && (!out_valid_q || out_ready_i);
  assign front_push_val = back_top.val;

  always_comb begin
    state_d    = state_q;
    popped_d   = popped_q;
    err_d      = err_q;
    front_ctrl = '0;
    back_ctrl  = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        popped_d = '0;
        err_d    = mmq_pkg::ERR_OK;
        state_d  = ST_REPORT;
        if (act_q == mmq_pkg::ACT_PUSH) begin
          if (held == mmq_pkg::COUNT_W'(mmq_pkg::DEPTH)) begin
            err_d = mmq_pkg::ERR_PUSH_FULL;
          end else begin
            back_ctrl.push = 1'b1;
          end
        end else if (held == '0) begin
          err_d = mmq_pkg::ERR_POP_EMPTY;
        end else if (front_depth == '0) begin
          // Refill the front stack first, then retry the pop.
          state_d = ST_MOVE;
        end else begin
          front_ctrl.pop = 1'b1;
          popped_d       = front_top.val;
        end
      end
      ST_MOVE: begin
        back_ctrl.pop   = 1'b1;
        front_ctrl.push = 1'b1;
        if (back_depth == mmq_pkg::COUNT_W'(1)) begin
          state_d = ST_EXEC;
        end
      end
      ST_REPORT: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rep_oldest = '0;
    rep_min    = mmq_pkg::VAL_MAX;
    rep_max    = mmq_pkg::VAL_MIN;
    if (front_depth != '0) begin
      rep_oldest = front_top.val;
      rep_min    = front_top.mn;
      rep_max    = front_top.mx;
    end else if (back_depth != '0) begin
      rep_oldest = bottom_q;
    end
    if (back_depth != '0) begin
      if ($signed(back_top.mn) < $signed(rep_min)) begin
        rep_min = back_top.mn;
      end
      if ($signed(back_top.mx) > $signed(rep_max)) begin
        rep_max = back_top.mx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q   <= action_i;
      value_q <= value_i;
    end
    popped_q <= popped_d;
    err_q    <= err_d;
    // Track the oldest entry of the back stack: it is written only into an empty stack.
    if (back_ctrl.push && (back_depth == '0)) begin
      bottom_q <= value_q;
    end
    if (load_out) begin
      res_popped_q <= popped_q;
      res_oldest_q <= rep_oldest;
      res_min_q    <= rep_min;
      res_max_q    <= rep_max;
      res_count_q  <= held;
      res_err_q    <= err_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign popped_value_o = res_popped_q;
  assign oldest_value_o = res_oldest_q;
  assign window_min_o   = res_min_q;
  assign window_max_o   = res_max_q;
  assign held_count_o   = res_count_q;
  assign error_code_o   = res_err_q;

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, front_depth} + {1'b0, back_depth}) <= (mmq_pkg::COUNT_W + 1)'(mmq_pkg::DEPTH))
    else $error("held count exceeds capacity");

  a_move_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOVE) |-> (back_depth != '0))
    else $error("stack transfer with an empty back stack");

  a_pop_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (error_code_o == mmq_pkg::ERR_POP_EMPTY)) |-> (held_count_o == '0))
    else $error("pop-empty error reported with values held");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_EXEC))
    else $error("accepted transaction not executed");

endmodule

`default_nettype wire

// ===== verif/min_max_fifo_queue_top_test.sv =====
`timescale 1ns / 1ps

module min_max_fifo_queue_top_test;

  localparam int unsigned CALM_TAIL   = 150;
  localparam int unsigned RANDOM_OPS  = 1400;
  localparam int unsigned HOLD_AT     = 400;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_WAIT  = mmq_pkg::DEPTH + 16;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic                                   act;
    logic signed [mmq_pkg::VALUE_WIDTH-1:0] val;
  } queue_op_t;

  typedef struct packed {
    logic signed [mmq_pkg::VALUE_WIDTH-1:0] popped;
    logic signed [mmq_pkg::VALUE_WIDTH-1:0] oldest;
    logic signed [mmq_pkg::VALUE_WIDTH-1:0] lo;
    logic signed [mmq_pkg::VALUE_WIDTH-1:0] hi;
    logic [mmq_pkg::COUNT_W-1:0]            count;
    logic [mmq_pkg::ERR_W-1:0]              err;
  } queue_status_t;

  logic                                   clk_i       = 1'b0;
  logic                                   rst_ni      = 1'b0;
  logic                                   in_valid_i  = 1'b0;
  logic                                   action_i    = mmq_pkg::ACT_PUSH;
  logic signed [mmq_pkg::VALUE_WIDTH-1:0] value_i     = '0;
  logic                                   out_ready_i = 1'b0;
  logic                                   in_ready_o;
  logic                                   out_valid_o;
  logic signed [mmq_pkg::VALUE_WIDTH-1:0] popped_value_o;
  logic signed [mmq_pkg::VALUE_WIDTH-1:0] oldest_value_o;
  logic signed [mmq_pkg::VALUE_WIDTH-1:0] window_min_o;
  logic signed [mmq_pkg::VALUE_WIDTH-1:0] window_max_o;
  logic [mmq_pkg::COUNT_W-1:0]            held_count_o;
  logic [mmq_pkg::ERR_W-1:0]              error_code_o;

  queue_op_t                              pending_ops[$];
  queue_op_t                              next_op;
  logic signed [mmq_pkg::VALUE_WIDTH-1:0] model_fifo[$];
  queue_status_t                          expected_status_q[$];

  int unsigned total_ops;
  int unsigned ops_accepted;
  int unsigned results_seen;
  int unsigned mismatch_cnt;
  int unsigned full_pushes;
  int unsigned empty_pops;
  int unsigned good_pops;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned hold_left;
  bit          hold_done;

  min_max_fifo_queue_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .popped_value_o(popped_value_o),
    .oldest_value_o(oldest_value_o),
    .window_min_o  (window_min_o),
    .window_max_o  (window_max_o),
    .held_count_o  (held_count_o),
    .error_code_o  (error_code_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic bit idling_allowed();
    return pending_ops.size() >= CALM_TAIL;
  endfunction

  // Compute the status the queue reports after one push or pop.
  task automatic predict_queue_op(input logic act,
                                  input logic signed [mmq_pkg::VALUE_WIDTH-1:0] val);
    queue_status_t st;
    st        = '0;
    st.err    = mmq_pkg::ERR_OK;
    st.lo     = mmq_pkg::VAL_MAX;
    st.hi     = mmq_pkg::VAL_MIN;
    if (act == mmq_pkg::ACT_PUSH) begin
      if (model_fifo.size() >= mmq_pkg::DEPTH) begin
        st.err = mmq_pkg::ERR_PUSH_FULL;
        full_pushes++;
      end else begin
        model_fifo = {model_fifo, val};
      end
    end else if (model_fifo.size() == 0) begin
      st.err = mmq_pkg::ERR_POP_EMPTY;
      empty_pops++;
    end else begin
      st.popped = model_fifo[0];
      model_fifo.delete(0);
      good_pops++;
    end
    foreach (model_fifo[i]) begin
      if (model_fifo[i] < st.lo) st.lo = model_fifo[i];
      if (model_fifo[i] > st.hi) st.hi = model_fifo[i];
    end
    if (model_fifo.size() != 0) st.oldest = model_fifo[0];
    st.count = mmq_pkg::COUNT_W'(model_fifo.size());
    expected_status_q = {expected_status_q, st};
  endtask

  task automatic check_status();
    queue_status_t got;
    queue_status_t want;
    got = '{popped_value_o, oldest_value_o, window_min_o, window_max_o,
            held_count_o, error_code_o};
    if (expected_status_q.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= MAX_REPORTS)
        $display("[%0t] unexpected result: pop=%0d old=%0d min=%0d max=%0d cnt=%0d err=%0d",
                 $time, $signed(got.popped), $signed(got.oldest), $signed(got.lo),
                 $signed(got.hi), got.count, got.err);
    end else begin
      want = expected_status_q[0];
      expected_status_q.delete(0);
      if (got !== want) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
          $display("[%0t] mismatch on result %0d", $time, results_seen);
          $display("  expected: pop=%0d old=%0d min=%0d max=%0d cnt=%0d err=%0d",
                   $signed(want.popped), $signed(want.oldest), $signed(want.lo),
                   $signed(want.hi), want.count, want.err);
          $display("  actual:   pop=%0d old=%0d min=%0d max=%0d cnt=%0d err=%0d",
                   $signed(got.popped), $signed(got.oldest), $signed(got.lo),
                   $signed(got.hi), got.count, got.err);
        end
      end
    end
  endtask

  // Driver: hold valid and payload until the transaction goes through.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      action_i     <= mmq_pkg::ACT_PUSH;
      value_i      <= '0;
      send_gap     <= 0;
      ops_accepted <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_queue_op(action_i, value_i);
        ops_accepted <= ops_accepted + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (idling_allowed() && $urandom_range(0, 9) == 0) begin
          send_gap   <= $urandom_range(0, 13);
          in_valid_i <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          next_op    = pending_ops[0];
          pending_ops.delete(0);
          in_valid_i <= 1'b1;
          action_i   <= next_op.act;
          value_i    <= next_op.val;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off so the result path backs up into the input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: check every accepted result and throttle ready.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i  <= 1'b0;
      recv_gap     <= 0;
      results_seen <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        check_status();
        results_seen <= results_seen + 1;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap    <= recv_gap - 1;
        out_ready_i <= 1'b0;
      end else if (idling_allowed() && $urandom_range(0, 9) == 0) begin
        recv_gap    <= $urandom_range(0, 13);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic logic signed [mmq_pkg::VALUE_WIDTH-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return mmq_pkg::VAL_MAX;
      1:       return mmq_pkg::VAL_MIN;
      2, 3:    return $urandom_range(0, 16) - 8;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_op(input logic act, input logic signed [mmq_pkg::VALUE_WIDTH-1:0] val);
    queue_op_t op;
    op.act = act;
    op.val = val;
    pending_ops = {pending_ops, op};
  endtask

  initial begin
    int unsigned run_len;
    int unsigned mode;
    int unsigned n;

    // Directed: empty pops, extremes, transfer between stacks, oldest in back stack, ties.
    add_op(mmq_pkg::ACT_POP,  $urandom());
    add_op(mmq_pkg::ACT_PUSH, mmq_pkg::VAL_MAX);
    add_op(mmq_pkg::ACT_POP,  $urandom());
    add_op(mmq_pkg::ACT_POP,  $urandom());
    add_op(mmq_pkg::ACT_PUSH, mmq_pkg::VAL_MIN);
    add_op(mmq_pkg::ACT_PUSH, mmq_pkg::VAL_MAX);
    add_op(mmq_pkg::ACT_PUSH, '0);
    add_op(mmq_pkg::ACT_PUSH, -1);
    add_op(mmq_pkg::ACT_PUSH, 1);
    add_op(mmq_pkg::ACT_POP,  $urandom());
    add_op(mmq_pkg::ACT_PUSH, 5);
    add_op(mmq_pkg::ACT_POP,  $urandom());
    add_op(mmq_pkg::ACT_POP,  $urandom());
    add_op(mmq_pkg::ACT_POP,  $urandom());
    add_op(mmq_pkg::ACT_POP,  $urandom());
    add_op(mmq_pkg::ACT_POP,  $urandom());
    add_op(mmq_pkg::ACT_POP,  $urandom());
    add_op(mmq_pkg::ACT_PUSH, -1);
    add_op(mmq_pkg::ACT_PUSH, -1);
    add_op(mmq_pkg::ACT_POP,  $urandom());
    add_op(mmq_pkg::ACT_POP,  $urandom());

    // Random runs: long push runs hit full, long pop runs drain and hit empty.
    n = 0;
    while (n < RANDOM_OPS) begin
      mode = $urandom_range(0, 9);
      run_len = (mode < 7) ? $urandom_range(1, mmq_pkg::DEPTH + 16) : $urandom_range(1, 40);
      repeat (run_len) begin
        if (mode < 4)
          add_op(mmq_pkg::ACT_PUSH, pick_value());
        else if (mode < 7)
          add_op(mmq_pkg::ACT_POP, $urandom());
        else
          add_op($urandom_range(0, 1) ? mmq_pkg::ACT_POP : mmq_pkg::ACT_PUSH, pick_value());
        n++;
      end
    end
    total_ops = pending_ops.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (ops_accepted < total_ops) @(posedge clk_i);
    while (expected_status_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Checked %0d results from %0d transactions, %0d mismatches.",
             results_seen, total_ops, mismatch_cnt);
    $display("Good pops %0d, pushes into full queue %0d, pops from empty queue %0d.",
             good_pops, full_pushes, empty_pops);
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout: %0d of %0d transactions accepted, %0d results pending.",
             ops_accepted, total_ops, expected_status_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
